[rtl/rmat_pkg.sv]
// Shared types, widths and register indexes of the R-MAT edge generator.
`default_nettype none

package rmat_pkg;

  localparam int STATE_W      = 64;
  localparam int WEIGHT_W     = 64;
  localparam int IDX_W        = 60;
  localparam int LVL_CFG_W    = 6;
  // Holds a saturated level count for any level depth up to 64.
  localparam int LVL_W        = 7;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_LEVELS_D = 60;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WEIGHT_A    = 2'd0,
    CFG_WEIGHT_B    = 2'd1,
    CFG_WEIGHT_C    = 2'd2,
    CFG_LEVEL_COUNT = 2'd3
  } cfg_idx_t;

  // Quadrant thresholds, sums formed modulo 2^64.
  typedef struct packed {
    logic [WEIGHT_W-1:0] a;
    logic [WEIGHT_W-1:0] ab;
    logic [WEIGHT_W-1:0] abc;
  } thr_t;

  // One word as it moves down the level pipeline.
  typedef struct packed {
    logic               valid;
    logic [STATE_W-1:0] state;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [LVL_W-1:0]   levels;
  } stage_t;

endpackage

`default_nettype wire

[rtl/rmat_cfg.sv]
// Configuration registers with precomputed quadrant thresholds.
`default_nettype none

module rmat_cfg #(
  parameter int MAX_LEVELS = rmat_pkg::MAX_LEVELS_D
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [rmat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rmat_pkg::WEIGHT_W-1:0]  cfg_wdata,
  output rmat_pkg::thr_t                      thr,
  output logic [rmat_pkg::LVL_W-1:0]          levels
);
  import rmat_pkg::*;

  logic [WEIGHT_W-1:0]  a_r, b_r, c_r, ab_r, abc_r;
  logic [WEIGHT_W-1:0]  a_nxt, b_nxt, c_nxt, ab_nxt, abc_nxt;
  logic [LVL_CFG_W-1:0] lvl_r, lvl_nxt;

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    c_nxt   = c_r;
    lvl_nxt = lvl_r;
    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WEIGHT_A:    a_nxt   = cfg_wdata;
        CFG_WEIGHT_B:    b_nxt   = cfg_wdata;
        CFG_WEIGHT_C:    c_nxt   = cfg_wdata;
        CFG_LEVEL_COUNT: lvl_nxt = cfg_wdata[LVL_CFG_W-1:0];
        default: ;
      endcase
    end
    // The sums are settled at write time so the level stages see plain registers.
    ab_nxt  = a_nxt + b_nxt;
    abc_nxt = ab_nxt + c_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r   <= '0;
      b_r   <= '0;
      c_r   <= '0;
      ab_r  <= '0;
      abc_r <= '0;
      lvl_r <= LVL_CFG_W'(1);
    end else begin
      a_r   <= a_nxt;
      b_r   <= b_nxt;
      c_r   <= c_nxt;
      ab_r  <= ab_nxt;
      abc_r <= abc_nxt;
      lvl_r <= lvl_nxt;
    end
  end

  assign thr.a   = a_r;
  assign thr.ab  = ab_r;
  assign thr.abc = abc_r;

  assign levels = (LVL_W'(lvl_r) > LVL_W'(MAX_LEVELS)) ? LVL_W'(MAX_LEVELS)
                                                       : LVL_W'(lvl_r);

endmodule

`default_nettype wire

[rtl/rmat_level.sv]
// One level of the edge pipeline: quadrant pick, index bit append, xorshift step.
`default_nettype none

module rmat_level #(
  parameter int LEVEL = 0
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire rmat_pkg::thr_t   thr,
  input  wire rmat_pkg::stage_t stg_i,
  output rmat_pkg::stage_t      stg_o
);
  import rmat_pkg::*;

  localparam int SH_A = 13;
  localparam int SH_B = 7;
  localparam int SH_C = 17;

  logic               valid_r;
  logic [STATE_W-1:0] state_r, state_nxt;
  logic [IDX_W-1:0]   row_r, row_nxt;
  logic [IDX_W-1:0]   col_r, col_nxt;
  logic [LVL_W-1:0]   levels_r;
  logic [STATE_W-1:0] s, t1, t2;
  logic               active, rbit, cbit;

  always_comb begin
    s      = stg_i.state;
    active = LVL_W'(LEVEL) < stg_i.levels;
    rbit   = s > thr.ab;
    cbit   = ((s > thr.a) && (s <= thr.ab)) || (s > thr.abc);
    row_nxt = active ? {stg_i.row[IDX_W-2:0], rbit} : stg_i.row;
    col_nxt = active ? {stg_i.col[IDX_W-2:0], cbit} : stg_i.col;
    t1 = s ^ (s << SH_A);
    t2 = t1 ^ (t1 >> SH_B);
    state_nxt = t2 ^ (t2 << SH_C);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= stg_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    state_r  <= state_nxt;
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    levels_r <= stg_i.levels;
  end

  assign stg_o.valid  = valid_r;
  assign stg_o.state  = state_r;
  assign stg_o.row    = row_r;
  assign stg_o.col    = col_r;
  assign stg_o.levels = levels_r;

endmodule

`default_nettype wire

[rtl/rmat_edge_generator.sv]
// Top level of the R-MAT edge generator: configuration and the level pipeline.
//
// Usage: write weight_a, weight_b, weight_c (indexes 0..2) and level_count
// (index 3) through cfg_we/cfg_index/cfg_wdata while no edge is in flight.
// An edge word enters when start is high and busy is low; in_random_state is
// the xorshift starting state of that edge. Each configured level is one
// pipeline register stage, so a result appears on out_row_index and
// out_col_index, with out_valid high for exactly one cycle, once it has passed
// all MAX_LEVELS stages. Stages beyond the configured level count pass the indexes
// through, so latency does not depend on level_count.
// Throughput is one edge per cycle; busy is high only during reset.
// Reset clears all valid bits and sets weights to 0 and level_count to 1.
// The receiver cannot stall, so the pipeline never holds; results leave in
// the order their starts were accepted.
`default_nettype none

module rmat_edge_generator #(
  parameter int MAX_LEVELS = rmat_pkg::MAX_LEVELS_D
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [rmat_pkg::STATE_W-1:0]   in_random_state,
  output logic                                out_valid,
  output logic [rmat_pkg::IDX_W-1:0]          out_row_index,
  output logic [rmat_pkg::IDX_W-1:0]          out_col_index,
  input  wire logic                           cfg_we,
  input  wire logic [rmat_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rmat_pkg::WEIGHT_W-1:0]  cfg_wdata
);
  import rmat_pkg::*;

  thr_t             thr;
  logic [LVL_W-1:0] levels;
  stage_t           stg [0:MAX_LEVELS];

  rmat_cfg #(
    .MAX_LEVELS(MAX_LEVELS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .thr       (thr),
    .levels    (levels)
  );

  assign busy = !rst_n;

  assign stg[0].valid  = start && !busy;
  assign stg[0].state  = in_random_state;
  assign stg[0].row    = '0;
  assign stg[0].col    = '0;
  assign stg[0].levels = levels;

  for (genvar k = 0; k < MAX_LEVELS; k++) begin : g_level
    rmat_level #(
      .LEVEL(k)
    ) u_level (
      .clk   (clk),
      .rst_n (rst_n),
      .thr   (thr),
      .stg_i (stg[k]),
      .stg_o (stg[k+1])
    );
  end

  assign out_valid     = stg[MAX_LEVELS].valid;
  assign out_row_index = stg[MAX_LEVELS].row;
  assign out_col_index = stg[MAX_LEVELS].col;

  // Every accepted word comes out after passing through all MAX_LEVELS level stages.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(start && !busy, MAX_LEVELS))
    else $error("result strobe does not match accepted start");

  // The stored sums always differ by weight_c: thr.abc - thr.ab equals c_r.
  a_thr_ab : assert property (@(posedge clk) disable iff (!rst_n)
    (thr.abc - thr.ab) == u_cfg.c_r)
    else $error("threshold a+b+c out of step with weight_c");

  // The saturated level count never exceeds the pipeline depth.
  a_levels : assert property (@(posedge clk) disable iff (!rst_n)
    levels <= LVL_W'(MAX_LEVELS))
    else $error("level count exceeds pipeline depth");

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for the R-MAT edge generator with a built-in edge predictor.
`timescale 1ns / 100ps

module testbench;
  import rmat_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam logic [WEIGHT_W-1:0] ONES = '1;
  localparam logic [WEIGHT_W-1:0] QUARTER = 64'h4000_0000_0000_0000;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } idx_pair_t;

  typedef struct {
    logic [STATE_W-1:0] value;
    bit                 drain;
  } seed_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [STATE_W-1:0]   in_random_state = '0;
  logic                 out_valid;
  logic [IDX_W-1:0]     out_row_index;
  logic [IDX_W-1:0]     out_col_index;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_WEIGHT_A;
  logic [WEIGHT_W-1:0]  cfg_wdata = '0;

  seed_t     seed_queue[$];
  idx_pair_t exp_edges[$];

  // Configuration as seen by the predictor, updated when a write lands.
  logic [WEIGHT_W-1:0]  mdl_a = '0;
  logic [WEIGHT_W-1:0]  mdl_b = '0;
  logic [WEIGHT_W-1:0]  mdl_c = '0;
  logic [LVL_CFG_W-1:0] mdl_lvl = 6'd1;

  // Configuration last programmed by the stimulus side.
  logic [WEIGHT_W-1:0]  prog_a = '0;
  logic [WEIGHT_W-1:0]  prog_b = '0;
  logic [WEIGHT_W-1:0]  prog_c = '0;

  bit took = 1'b0;
  bit burst_mode = 1'b0;
  int gap_left = 0;
  int items_outstanding = 0;
  int item_cnt = 0;
  int setting_cnt = 1;
  int checked_cnt = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;

  rmat_edge_generator i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_random_state (in_random_state),
    .out_valid       (out_valid),
    .out_row_index   (out_row_index),
    .out_col_index   (out_col_index),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Walks the quadrant tree for one edge: one row bit and one column bit per level.
  function automatic idx_pair_t rmat_walk(logic [STATE_W-1:0] s, logic [WEIGHT_W-1:0] a,
                                          logic [WEIGHT_W-1:0] b, logic [WEIGHT_W-1:0] c,
                                          logic [LVL_CFG_W-1:0] lvl);
    logic [WEIGHT_W-1:0] ab;
    logic [WEIGHT_W-1:0] abc;
    int                  depth;
    idx_pair_t           r;
    ab = a + b;
    abc = ab + c;
    depth = (lvl > MAX_LEVELS_D) ? MAX_LEVELS_D : int'(lvl);
    r.row = '0;
    r.col = '0;
    for (int k = 0; k < depth; k++) begin
      r.row = {r.row[IDX_W-2:0], s > ab};
      r.col = {r.col[IDX_W-2:0], (s > a && s <= ab) || (s > abc)};
      s = s ^ (s << 13);
      s = s ^ (s >> 7);
      s = s ^ (s << 17);
    end
    return r;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 90);
  endfunction

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_cnt, exp_edges.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Driver: moves one word at a time from seed_queue onto the input ports.
  always @(negedge clk) begin
    logic  go;
    seed_t nxt;
    go = start;
    if (rst_n) begin
      if (start && took) begin
        go = 1'b0;
        gap_left = burst_mode ? 0 : pick_gap();
      end
      if (!go && gap_left > 0) begin
        gap_left--;
      end else if (!go && seed_queue.size() != 0 &&
                   !(seed_queue[0].drain && exp_edges.size() != 0)) begin
        nxt = seed_queue.pop_front();
        in_random_state <= nxt.value;
        go = 1'b1;
      end
    end
    start <= go;
  end

  // Monitor: predicts on every accepted word and checks every result strobe.
  always @(posedge clk) begin
    idx_pair_t got;
    idx_pair_t want;
    took = rst_n && start && !busy;
    if (took) begin
      exp_edges.push_back(rmat_walk(in_random_state, mdl_a, mdl_b, mdl_c, mdl_lvl));
      items_outstanding--;
    end
    if (rst_n && cfg_we) begin
      case (cfg_index)
        CFG_WEIGHT_A:    mdl_a = cfg_wdata;
        CFG_WEIGHT_B:    mdl_b = cfg_wdata;
        CFG_WEIGHT_C:    mdl_c = cfg_wdata;
        CFG_LEVEL_COUNT: mdl_lvl = cfg_wdata[LVL_CFG_W-1:0];
        default: ;
      endcase
    end
    if (rst_n && out_valid) begin
      got.row = out_row_index;
      got.col = out_col_index;
      if (exp_edges.size() == 0) begin
        $error("Unexpected result word: row_index %h, col_index %h", got.row, got.col);
        fail_cnt++;
      end else begin
        want = exp_edges.pop_front();
        checked_cnt++;
        if (got.row !== want.row) begin
          $error("row_index mismatch: expected %h, got %h", want.row, got.row);
          fail_cnt++;
        end
        if (got.col !== want.col) begin
          $error("col_index mismatch: expected %h, got %h", want.col, got.col);
          fail_cnt++;
        end
      end
    end
  end

  task automatic push_seed(logic [STATE_W-1:0] value, bit drain = 1'b0);
    seed_t s;
    s.value = value;
    s.drain = drain;
    seed_queue.push_back(s);
    items_outstanding++;
    item_cnt++;
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (items_outstanding != 0 || exp_edges.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [WEIGHT_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_cfg(logic [WEIGHT_W-1:0] a, logic [WEIGHT_W-1:0] b,
                             logic [WEIGHT_W-1:0] c, logic [LVL_CFG_W-1:0] lvl);
    write_reg(CFG_WEIGHT_A, a);
    write_reg(CFG_WEIGHT_B, b);
    write_reg(CFG_WEIGHT_C, c);
    write_reg(CFG_LEVEL_COUNT, {{(WEIGHT_W-LVL_CFG_W){1'b0}}, lvl});
    prog_a = a;
    prog_b = b;
    prog_c = c;
    setting_cnt++;
  endtask

  initial begin
    logic [WEIGHT_W-1:0]  a;
    logic [WEIGHT_W-1:0]  b;
    logic [WEIGHT_W-1:0]  c;
    logic [LVL_CFG_W-1:0] lvl;
    logic [STATE_W-1:0]   thr;
    logic [STATE_W-1:0]   s;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration: all weights zero, a single level.
    push_seed('0);
    push_seed(64'd1);
    push_seed(ONES);
    wait_idle();

    // Even quadrants; states on and just above every threshold, and just below the first.
    program_cfg(QUARTER, QUARTER, QUARTER, 6'd60);
    push_seed('0);
    push_seed(ONES);
    push_seed(64'd1);
    push_seed(QUARTER - 1);
    push_seed(QUARTER);
    push_seed(QUARTER + 1);
    push_seed(2 * QUARTER);
    push_seed(2 * QUARTER + 1);
    push_seed(3 * QUARTER);
    push_seed(3 * QUARTER + 1);
    push_seed(64'h5555_5555_5555_5555);
    push_seed(64'hAAAA_AAAA_AAAA_AAAA);
    wait_idle();

    // No levels at all gives zero indexes.
    program_cfg(QUARTER, QUARTER, QUARTER, 6'd0);
    push_seed(ONES);
    push_seed(rand64());
    wait_idle();

    // Level counts above the pipeline depth saturate.
    write_reg(CFG_LEVEL_COUNT, 64'd63);
    push_seed(rand64());
    push_seed(64'h8000_0000_0000_0000);
    wait_idle();

    // Both threshold sums wrap around: a+b = 1, a+b+c = 0.
    program_cfg(ONES, 64'd2, ONES, 6'd61);
    push_seed(64'd1);
    push_seed(64'd2);
    wait_idle();

    for (int p = 0; p < 11; p++) begin
      case (p % 5)
        0: begin
          // Typical skewed R-MAT split.
          a = 64'h9200_0000_0000_0000 | {32'd0, $urandom};
          b = 64'h3000_0000_0000_0000 | {32'd0, $urandom};
          c = 64'h3000_0000_0000_0000 | {32'd0, $urandom};
        end
        1: begin
          a = rand64();
          b = rand64();
          c = rand64();
        end
        2: begin
          a = ONES - $urandom_range(0, 1000);
          b = rand64() | 64'h8000_0000_0000_0000;
          c = rand64() | 64'h8000_0000_0000_0000;
        end
        3: begin
          a = $urandom_range(0, 1) ? ONES : '0;
          b = $urandom_range(0, 1) ? ONES : '0;
          c = $urandom_range(0, 1) ? ONES : '0;
        end
        default: begin
          a = rand64() >> $urandom_range(1, 40);
          b = rand64() >> $urandom_range(1, 40);
          c = rand64() >> $urandom_range(1, 40);
        end
      endcase
      case ($urandom_range(0, 5))
        0: lvl = 6'd60;
        1: lvl = 6'($urandom_range(61, 63));
        2: lvl = 6'd1;
        default: lvl = 6'($urandom_range(1, 60));
      endcase
      if (p == 7) lvl = 6'd0;
      program_cfg(a, b, c, lvl);
      burst_mode = (p % 4 == 1);

      for (int i = 0; i < 48; i++) begin
        case ($urandom_range(0, 9))
          6: begin
            case ($urandom_range(0, 2))
              0: thr = prog_a;
              1: thr = prog_a + prog_b;
              default: thr = prog_a + prog_b + prog_c;
            endcase
            s = thr + 64'($urandom_range(0, 2)) - 64'd1;
          end
          7: s = $urandom_range(0, 1) ? ONES : '0;
          8: s = rand64() >> $urandom_range(1, 63);
          default: s = rand64();
        endcase
        // Now and then hold the next word until the pipeline has drained.
        push_seed(s, i == 10 || $urandom_range(0, 79) == 0);
      end
      wait_idle();
    end

    wait_idle();
    repeat (MAX_LEVELS_D + 10) @(negedge clk);

    $display("Sent %0d edge states under %0d register settings; %0d results compared.",
             item_cnt, setting_cnt, checked_cnt);
    $display("Settings included zero, saturated and wrapping thresholds and levels.");
    if (fail_cnt == 0 && exp_edges.size() == 0) begin
      $display("CHECK OK");
    end else begin
      if (exp_edges.size() != 0)
        $error("%0d expected results never arrived", exp_edges.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
